>>> rtl/utf8v_pkg.sv
package utf8v_pkg;

  localparam int BYTE_W = 8;
  localparam int ERR_W  = 3;
  // A stored code point needs at most 16 bits; one more continuation adds six.
  localparam int CP_W   = 16;
  localparam int VAL_W  = CP_W + 6;

  localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_LEAD     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MISSING_CONT = 3'd2;
  localparam logic [ERR_W-1:0] ERR_SURROGATE    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TOO_LARGE    = 3'd4;

  localparam logic [BYTE_W-1:0] BYTE_END      = 8'h00;
  localparam logic [BYTE_W-1:0] LEAD_ASCII_HI = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD_BAD_HI   = 8'hC1;
  localparam logic [BYTE_W-1:0] LEAD_TWO_HI   = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD_THREE_HI = 8'hEF;
  localparam logic [1:0]        CONT_TAG      = 2'b10;

  localparam logic [VAL_W-1:0] SURR_LO = 22'h00D800;
  localparam logic [VAL_W-1:0] SURR_HI = 22'h00DFFF;
  localparam logic [VAL_W-1:0] CP_MAX  = 22'h10FFFF;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] byte_value;
  } item_t;

  typedef struct packed {
    logic             is_valid;
    logic [ERR_W-1:0] error_kind;
  } verdict_t;

endpackage

>>> rtl/utf8_stream_validator_top.sv
// Channel   Direction  Payload                          Handshake
// in_       input      byte_value[7:0]                  in_valid / in_stall
// out_      output     is_valid, error_kind[2:0]        out_valid / out_stall
//
// One byte is taken each cycle while no zero byte waits for the result register; a verdict
// is registered as its zero byte is taken and is on the outputs in the cycle after.
// The rate is set by the single decode step between the input and result registers.
// Reset (synchronous, active low) clears the sequence state and both valid flags.
// Non-zero bytes keep flowing while a verdict waits; a zero byte waits until the result
// register is free, and in_stall then rises.
module utf8_stream_validator_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_valid,
  output logic [2:0] out_error_kind
);

  utf8v_pkg::item_t    item;
  utf8v_pkg::verdict_t verdict;
  logic                take;
  logic                emit;
  logic                out_ready;

  utf8v_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .take          (take),
    .item          (item)
  );

  utf8v_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .out_ready (out_ready),
    .take      (take),
    .emit      (emit),
    .verdict   (verdict)
  );

  utf8v_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .emit           (emit),
    .verdict        (verdict),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_valid   (out_is_valid),
    .out_error_kind (out_error_kind)
  );

endmodule

>>> rtl/utf8v_in_stage.sv
module utf8v_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [utf8v_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic                          take,
  output utf8v_pkg::item_t              item
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic [utf8v_pkg::BYTE_W-1:0] byte_r;
  logic                         accept;

  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte_value;
    end
  end

  assign item.valid      = valid_r;
  assign item.byte_value = byte_r;

endmodule

>>> rtl/utf8v_decoder.sv
module utf8v_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf8v_pkg::item_t     item,
  input  logic                 out_ready,
  output logic                 take,
  output logic                 emit,
  output utf8v_pkg::verdict_t  verdict
);

  logic [1:0]                  pend_r, pend_nxt;
  logic [1:0]                  len_r, len_nxt;
  logic [utf8v_pkg::CP_W-1:0]  cp_r, cp_nxt;
  logic [utf8v_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [utf8v_pkg::VAL_W-1:0] value;
  logic [1:0]                  pend_dec;
  logic [utf8v_pkg::ERR_W-1:0] end_err;
  logic [7:0]                  b;
  logic                        is_end;

  assign b      = item.byte_value;
  assign is_end = (b == utf8v_pkg::BYTE_END);
  // A byte that yields no verdict may move on even while the result register is full.
  assign take   = item.valid && (!is_end || out_ready);
  assign emit   = take && is_end;

  assign value    = {cp_r, b[5:0]};
  assign pend_dec = pend_r - 2'd1;
  assign end_err  = (err_r == utf8v_pkg::ERR_NONE && pend_r != 2'd0) ?
                    utf8v_pkg::ERR_MISSING_CONT : err_r;

  assign verdict.is_valid   = (end_err == utf8v_pkg::ERR_NONE);
  assign verdict.error_kind = end_err;

  always_comb begin
    pend_nxt = pend_r;
    len_nxt  = len_r;
    cp_nxt   = cp_r;
    err_nxt  = err_r;
    if (take) begin
      if (is_end) begin
        pend_nxt = 2'd0;
        len_nxt  = 2'd0;
        cp_nxt   = '0;
        err_nxt  = utf8v_pkg::ERR_NONE;
      end else if (err_r != utf8v_pkg::ERR_NONE) begin
        // Everything up to the terminator is ignored once an error is held.
      end else if (pend_r == 2'd0) begin
        if (b inside {[utf8v_pkg::LEAD_ASCII_HI + 8'd1 : utf8v_pkg::LEAD_BAD_HI]}) begin
          err_nxt = utf8v_pkg::ERR_BAD_LEAD;
        end else if (b > utf8v_pkg::LEAD_BAD_HI) begin
          cp_nxt = {{(utf8v_pkg::CP_W-4){1'b0}}, b[3:0]};
          if (b <= utf8v_pkg::LEAD_TWO_HI) begin
            len_nxt  = 2'd1;
            pend_nxt = 2'd1;
          end else if (b <= utf8v_pkg::LEAD_THREE_HI) begin
            len_nxt  = 2'd2;
            pend_nxt = 2'd2;
          end else begin
            len_nxt  = 2'd3;
            pend_nxt = 2'd3;
          end
        end
      end else if (b[7:6] != utf8v_pkg::CONT_TAG) begin
        err_nxt  = utf8v_pkg::ERR_MISSING_CONT;
        pend_nxt = 2'd0;
        len_nxt  = 2'd0;
        cp_nxt   = '0;
      end else if (pend_dec != 2'd0) begin
        pend_nxt = pend_dec;
        cp_nxt   = value[utf8v_pkg::CP_W-1:0];
      end else begin
        if (len_r == 2'd2 && value inside {[utf8v_pkg::SURR_LO : utf8v_pkg::SURR_HI]}) begin
          err_nxt = utf8v_pkg::ERR_SURROGATE;
        end else if (len_r == 2'd3 && value > utf8v_pkg::CP_MAX) begin
          err_nxt = utf8v_pkg::ERR_TOO_LARGE;
        end
        pend_nxt = 2'd0;
        len_nxt  = 2'd0;
        cp_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      len_r  <= 2'd0;
      cp_r   <= '0;
      err_r  <= utf8v_pkg::ERR_NONE;
    end else begin
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      cp_r   <= cp_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

>>> rtl/utf8v_out_stage.sv
module utf8v_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          emit,
  input  utf8v_pkg::verdict_t           verdict,
  output logic                          out_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_valid,
  output logic [utf8v_pkg::ERR_W-1:0]   out_error_kind
);

  logic                valid_r;
  logic                valid_nxt;
  utf8v_pkg::verdict_t verdict_r;

  assign out_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      verdict_r <= verdict;
    end
  end

  assign out_valid      = valid_r;
  assign out_is_valid   = verdict_r.is_valid;
  assign out_error_kind = verdict_r.error_kind;

endmodule
